### hdl/pip_pkg.sv
`default_nettype none

package pip_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int unsigned PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;

  typedef enum logic [1:0] {
    DEC_BOX    = 2'd0,
    DEC_VERTEX = 2'd1,
    DEC_PARITY = 2'd2
  } dec_e;

  typedef struct packed {
    logic   first;
    logic   last;
    coord_t point_x;
    coord_t point_y;
    coord_t box_x_low;
    coord_t box_y_low;
    coord_t box_x_high;
    coord_t box_y_high;
    coord_t vertex_x;
    coord_t vertex_y;
  } in_item_t;

  typedef struct packed {
    logic inside_res;
    dec_e decided_by;
  } out_item_t;

  typedef struct packed {
    logic   en;
    coord_t cx;
    coord_t cy;
    coord_t ox;
    coord_t oy;
  } edge_t;

  typedef struct packed {
    logic   clr;
    logic   emit;
    logic   early;
    dec_e   code;
    coord_t qx;
    coord_t qy;
    edge_t  e1;
    edge_t  e2;
  } job_t;

  typedef struct packed {
    logic  hit;
    logic  up;
    logic  dn;
    prod_t p1;
    prod_t p2;
  } prep_t;

  typedef struct packed {
    logic  clr;
    logic  emit;
    logic  early;
    dec_e  code;
    prep_t x1;
    prep_t x2;
  } stage_t;

  function automatic diff_t sub_ext(coord_t a, coord_t b);
    diff_t wa;
    diff_t wb;
    wa = $signed({a[COORD_WIDTH-1], a});
    wb = $signed({b[COORD_WIDTH-1], b});
    return wa - wb;
  endfunction

  function automatic prep_t crossing_prep(edge_t e, coord_t x, coord_t y);
    prep_t  p;
    coord_t cx;
    coord_t cy;
    coord_t ox;
    coord_t oy;
    diff_t  da;
    diff_t  db;
    diff_t  dc;
    diff_t  dd;
    cx = e.cx;
    cy = e.cy;
    ox = e.ox;
    oy = e.oy;
    da = sub_ext(ox, cx);
    db = sub_ext(y, cy);
    dc = sub_ext(oy, cy);
    dd = sub_ext(x, cx);
    p.hit = e.en && ((cy >= y && oy <= y) || (cy <= y && oy >= y));
    p.up  = oy > cy;
    p.dn  = oy < cy;
    p.p1  = da * db;
    p.p2  = dc * dd;
    return p;
  endfunction

  function automatic logic crossing_eval(prep_t p);
    prod_t p1;
    prod_t p2;
    p1 = p.p1;
    p2 = p.p2;
    return p.hit && ((p.up && p1 > p2) || (p.dn && p1 < p2));
  endfunction

endpackage

`default_nettype wire

### hdl/pip_front.sv
`default_nettype none

module pip_front (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  pip_pkg::in_item_t   in_item_i,
  output logic                push_o,
  output pip_pkg::job_t       job_o,
  input  wire                 full_i
);

  pip_pkg::coord_t qx_q, qx_d, qy_q, qy_d;
  pip_pkg::coord_t sx_q, sx_d, sy_q, sy_d;
  pip_pkg::coord_t px_q, px_d, py_q, py_d;
  logic            early_q, early_d;
  pip_pkg::dec_e   code_q, code_d;
  logic            lor_q, lor_d;

  pip_pkg::coord_t vx, vy, ptx, pty, bxl, byl, bxh, byh;
  logic            accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    vx  = in_item_i.vertex_x;
    vy  = in_item_i.vertex_y;
    ptx = in_item_i.point_x;
    pty = in_item_i.point_y;
    bxl = in_item_i.box_x_low;
    byl = in_item_i.box_y_low;
    bxh = in_item_i.box_x_high;
    byh = in_item_i.box_y_high;

    qx_d    = qx_q;
    qy_d    = qy_q;
    sx_d    = sx_q;
    sy_d    = sy_q;
    px_d    = px_q;
    py_d    = py_q;
    early_d = early_q;
    code_d  = code_q;
    lor_d   = lor_q;
    job_o   = '0;

    if (in_item_i.first) begin
      qx_d    = ptx;
      qy_d    = pty;
      lor_d   = 1'b0;
      early_d = 1'b0;
      code_d  = pip_pkg::DEC_BOX;
      if (ptx < bxl || pty < byl || ptx > bxh || pty > byh) begin
        early_d = 1'b1;
      end else if (vy == pty && vx >= ptx) begin
        if (vx == ptx) begin
          early_d = 1'b1;
          code_d  = pip_pkg::DEC_VERTEX;
        end else begin
          vx = vx - pip_pkg::COORD_WIDTH'(1);
        end
      end
      sx_d = vx;
      sy_d = vy;
      px_d = vx;
      py_d = vy;
    end else if (!early_q) begin
      if (vy == qy_q && vx >= qx_q) begin
        if (vx == qx_q) begin
          early_d = 1'b1;
          code_d  = pip_pkg::DEC_VERTEX;
        end
        lor_d = 1'b1;
      end else begin
        job_o.e1.en = 1'b1;
        job_o.e1.cx = vx;
        job_o.e1.cy = vy;
        job_o.e1.ox = px_q;
        job_o.e1.oy = py_q;
        px_d        = vx;
        py_d        = vy;
        lor_d       = 1'b0;
      end
    end

    job_o.clr   = in_item_i.first;
    job_o.emit  = in_item_i.last;
    job_o.early = early_d;
    job_o.code  = code_d;
    job_o.qx    = qx_d;
    job_o.qy    = qy_d;
    job_o.e2.en = in_item_i.last && !early_d && !lor_d;
    job_o.e2.cx = px_d;
    job_o.e2.cy = py_d;
    job_o.e2.ox = sx_d;
    job_o.e2.oy = sy_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q    <= '0;
      qy_q    <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      px_q    <= '0;
      py_q    <= '0;
      early_q <= 1'b0;
      code_q  <= pip_pkg::DEC_BOX;
      lor_q   <= 1'b0;
    end else if (accept) begin
      qx_q    <= qx_d;
      qy_q    <= qy_d;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      px_q    <= px_d;
      py_q    <= py_d;
      early_q <= early_d;
      code_q  <= code_d;
      lor_q   <= lor_d;
    end
  end

endmodule

`default_nettype wire

### hdl/pip_queue.sv
`default_nettype none

module pip_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  pip_pkg::job_t  data_i,
  output logic           full_o,
  input  wire            pop_i,
  output logic           valid_o,
  output pip_pkg::job_t  data_o
);

  localparam int unsigned PW = pip_pkg::QUEUE_PTR_W;
  localparam int unsigned CW = pip_pkg::QUEUE_CNT_W;

  pip_pkg::job_t  mem_q [pip_pkg::QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == CW'(pip_pkg::QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(pip_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PW'(pip_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(pip_pkg::QUEUE_DEPTH)) else $error("queue count overflow");
`endif

endmodule

`default_nettype wire

### hdl/pip_back.sv
`default_nettype none

module pip_back (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 job_valid_i,
  input  pip_pkg::job_t       job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output pip_pkg::out_item_t  out_item_o
);

  logic                s1_valid_q, s1_valid_d;
  pip_pkg::stage_t     s1_q, s1_d;
  logic                par_q, par_d;
  logic                out_valid_q, out_valid_d;
  pip_pkg::out_item_t  out_q, out_d;

  logic out_free, s1_go, s1_load, x1, x2, par_run;

  assign out_free = !out_valid_q || !out_stall_i;
  assign s1_go    = s1_valid_q && (!s1_q.emit || out_free);
  assign s1_load  = !s1_valid_q || s1_go;
  assign pop_o    = job_valid_i && s1_load;

  assign x1      = pip_pkg::crossing_eval(s1_q.x1);
  assign x2      = pip_pkg::crossing_eval(s1_q.x2);
  assign par_run = (s1_q.clr ? 1'b0 : par_q) ^ x1;

  always_comb begin
    s1_d.clr   = job_i.clr;
    s1_d.emit  = job_i.emit;
    s1_d.early = job_i.early;
    s1_d.code  = job_i.code;
    s1_d.x1    = pip_pkg::crossing_prep(job_i.e1, job_i.qx, job_i.qy);
    s1_d.x2    = pip_pkg::crossing_prep(job_i.e2, job_i.qx, job_i.qy);
    s1_valid_d = s1_load ? job_valid_i : s1_valid_q;
    par_d      = s1_go ? par_run : par_q;

    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_go && s1_q.emit) begin
      out_valid_d = 1'b1;
      if (s1_q.early) begin
        out_d.inside_res = s1_q.code == pip_pkg::DEC_VERTEX;
        out_d.decided_by = s1_q.code;
      end else begin
        out_d.inside_res = par_run ^ x2;
        out_d.decided_by = pip_pkg::DEC_PARITY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q <= s1_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTH
  a_box_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.decided_by == pip_pkg::DEC_BOX |-> !out_item_o.inside_res)
    else $error("box decision reported inside");
  a_vertex_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.decided_by == pip_pkg::DEC_VERTEX |-> out_item_o.inside_res)
    else $error("vertex decision reported outside");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_q.emit && out_valid_q && out_stall_i |=> s1_valid_q)
    else $error("pending result dropped while output busy");
`endif

endmodule

`default_nettype wire

### hdl/point_in_polygon_test.sv
// Channel   Direction  Valid        Stall         Payload
// input     in         in_valid_i   in_stall_o    in_item_i  (pip_pkg::in_item_t)
// output    out        out_valid_o  out_stall_i   out_item_o (pip_pkg::out_item_t)
//
// One vertex transfer per cycle while in_stall_o is low; the front updates polygon state at each transfer.
// After the last vertex's transfer, a result passes through the job queue,
// then a product stage (four multipliers), then compare and parity.
// Reset clears the polygon state to zeros, empties the queue and the output.
// A stalled output holds the back end at a result; the two-entry queue then
// fills and in_stall_o rises, without losing or repeating any vertex.
`default_nettype none

module point_in_polygon_test (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  pip_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output pip_pkg::out_item_t  out_item_o
);

  logic          push, full, qvalid, pop;
  pip_pkg::job_t job_in, job_out;

  pip_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  pip_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (qvalid),
    .data_o  (job_out)
  );

  pip_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qvalid),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### tb/sv/polygon_verdict_checker.sv
`default_nettype none

module polygon_verdict_checker
  import pip_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  wire        in_stall_i,
  input  in_item_t   in_item_i,
  input  wire        out_valid_i,
  input  wire        out_stall_i,
  input  out_item_t  out_item_i,
  output int         errors_o,
  output int         pending_o
);

  coord_t pt_x, pt_y;
  coord_t anchor_x, anchor_y;
  coord_t prev_x, prev_y;
  bit     parity;
  bit     decided;
  dec_e   decision;
  bit     prev_skipped;

  out_item_t verdicts_due[$];
  int        error_count = 0;
  int        due_count   = 0;

  assign errors_o  = error_count;
  assign pending_o = due_count;

  task automatic flag_mismatch(input string what);
    $display("ERROR %0t: %s", $time, what);
    error_count++;
  endtask

  function automatic bit hits_ray(coord_t x, coord_t y);
    return (y == pt_y) && (x >= pt_x);
  endfunction

  function automatic bit edge_crosses(coord_t cx, coord_t cy, coord_t ox, coord_t oy);
    longint lhs;
    longint rhs;
    bit     spans;
    spans = (cy >= pt_y && oy <= pt_y) || (cy <= pt_y && oy >= pt_y);
    lhs = (longint'(ox) - longint'(cx)) * (longint'(pt_y) - longint'(cy));
    rhs = (longint'(oy) - longint'(cy)) * (longint'(pt_x) - longint'(cx));
    return spans && ((oy > cy && lhs > rhs) || (oy < cy && lhs < rhs));
  endfunction

  task automatic advance_polygon(input in_item_t it);
    coord_t    vx, vy;
    coord_t    bxl, byl, bxh, byh;
    out_item_t verdict;
    bit        par;
    vx  = it.vertex_x;
    vy  = it.vertex_y;
    bxl = it.box_x_low;
    byl = it.box_y_low;
    bxh = it.box_x_high;
    byh = it.box_y_high;
    if (it.first) begin
      pt_x         = it.point_x;
      pt_y         = it.point_y;
      parity       = 1'b0;
      decided      = 1'b0;
      decision     = DEC_BOX;
      prev_skipped = 1'b0;
      if (pt_x < bxl || pt_y < byl || pt_x > bxh || pt_y > byh) begin
        decided  = 1'b1;
        decision = DEC_BOX;
      end else if (hits_ray(vx, vy)) begin
        if (vx == pt_x) begin
          decided  = 1'b1;
          decision = DEC_VERTEX;
        end else begin
          vx = vx - coord_t'(1);
        end
      end
      anchor_x = vx;
      anchor_y = vy;
      prev_x   = vx;
      prev_y   = vy;
    end else if (!decided) begin
      if (hits_ray(vx, vy)) begin
        if (vx == pt_x) begin
          decided  = 1'b1;
          decision = DEC_VERTEX;
        end
        prev_skipped = 1'b1;
      end else begin
        parity       = parity ^ edge_crosses(vx, vy, prev_x, prev_y);
        prev_x       = vx;
        prev_y       = vy;
        prev_skipped = 1'b0;
      end
    end
    if (it.last) begin
      if (decided) begin
        verdict.inside_res = (decision == DEC_VERTEX);
        verdict.decided_by = decision;
      end else begin
        par = parity;
        if (!prev_skipped) par = par ^ edge_crosses(prev_x, prev_y, anchor_x, anchor_y);
        verdict.inside_res = par;
        verdict.decided_by = DEC_PARITY;
      end
      verdicts_due.push_back(verdict);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      pt_x         = '0;
      pt_y         = '0;
      anchor_x     = '0;
      anchor_y     = '0;
      prev_x       = '0;
      prev_y       = '0;
      parity       = 1'b0;
      decided      = 1'b0;
      decision     = DEC_BOX;
      prev_skipped = 1'b0;
      verdicts_due.delete();
    end else begin
      if (in_valid_i && !in_stall_i) advance_polygon(in_item_i);
      if (out_valid_i && !out_stall_i) begin
        if (verdicts_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected result inside_res=%0b decided_by=%0d",
                                  out_item_i.inside_res, out_item_i.decided_by));
        end else begin
          want = verdicts_due.pop_front();
          if (out_item_i.inside_res !== want.inside_res)
            flag_mismatch($sformatf("inside_res got %0b want %0b",
                                    out_item_i.inside_res, want.inside_res));
          if (out_item_i.decided_by !== want.decided_by)
            flag_mismatch($sformatf("decided_by got %0d want %0d",
                                    out_item_i.decided_by, want.decided_by));
        end
      end
    end
    due_count = verdicts_due.size();
  end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`default_nettype none

module tb;
  import pip_pkg::*;

  localparam int CMIN = -32768;
  localparam int CMAX = 32767;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  int errors;
  int pending;
  int send_idle  = 9;
  int recv_idle  = 49;
  int items_sent = 0;
  int poly_x[$];
  int poly_y[$];

  point_in_polygon_test uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  polygon_verdict_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_item_i  (in_item),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_item_i (out_item),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_stall <= rst_n && (int'($urandom_range(0, 99)) < recv_idle);
  end

  function automatic int clamp_coord(int v);
    if (v < CMIN) return CMIN;
    if (v > CMAX) return CMAX;
    return v;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 65535)) + CMIN;
  endfunction

  function automatic int near_coord(int centre, int spread);
    return clamp_coord(centre + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  function automatic int extreme_coord(int centre);
    case ($urandom_range(0, 4))
      0:       return CMIN;
      1:       return CMAX;
      2:       return centre;
      3:       return clamp_coord(centre - 1);
      default: return clamp_coord(centre + 1);
    endcase
  endfunction

  function automatic in_item_t noise_item();
    in_item_t r;
    r.first      = 1'($urandom_range(0, 1));
    r.last       = 1'($urandom_range(0, 1));
    r.point_x    = coord_t'($urandom);
    r.point_y    = coord_t'($urandom);
    r.box_x_low  = coord_t'($urandom);
    r.box_y_low  = coord_t'($urandom);
    r.box_x_high = coord_t'($urandom);
    r.box_y_high = coord_t'($urandom);
    r.vertex_x   = coord_t'($urandom);
    r.vertex_y   = coord_t'($urandom);
    return r;
  endfunction

  task automatic send_vertex(input in_item_t it);
    while (int'($urandom_range(0, 99)) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic emit_polygon(input int px, input int py, input int bxl, input int byl,
                              input int bxh, input int byh, input bit closed);
    in_item_t it;
    for (int i = 0; i < poly_x.size(); i++) begin
      it       = noise_item();
      it.first = (i == 0);
      it.last  = closed && (i == poly_x.size() - 1);
      if (i == 0) begin
        it.point_x    = coord_t'(px);
        it.point_y    = coord_t'(py);
        it.box_x_low  = coord_t'(bxl);
        it.box_y_low  = coord_t'(byl);
        it.box_x_high = coord_t'(bxh);
        it.box_y_high = coord_t'(byh);
      end
      it.vertex_x = coord_t'(poly_x[i]);
      it.vertex_y = coord_t'(poly_y[i]);
      send_vertex(it);
    end
  endtask

  task automatic random_polygon();
    int px, py, bxl, byl, bxh, byh;
    int n, style, spread, x, y;
    bit closed;
    style  = $urandom_range(0, 9);
    spread = $urandom_range(1, 12);
    px     = (style == 9) ? extreme_coord(0) : any_coord();
    py     = (style == 9) ? extreme_coord(0) : any_coord();
    case ($urandom_range(0, 9))
      0: begin
        bxl = CMIN; byl = CMIN; bxh = CMAX; byh = CMAX;
      end
      1, 2: begin
        bxl = any_coord(); byl = any_coord(); bxh = any_coord(); byh = any_coord();
      end
      default: begin
        bxl = clamp_coord(px - int'($urandom_range(0, 20)));
        byl = clamp_coord(py - int'($urandom_range(0, 20)));
        bxh = clamp_coord(px + int'($urandom_range(0, 20)));
        byh = clamp_coord(py + int'($urandom_range(0, 20)));
      end
    endcase
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    poly_x.delete();
    poly_y.delete();
    repeat (n) begin
      if (style < 7) begin
        x = near_coord(px, spread);
        y = near_coord(py, spread);
      end else if (style < 9) begin
        x = any_coord();
        y = any_coord();
      end else begin
        x = extreme_coord(px);
        y = extreme_coord(py);
      end
      if ($urandom_range(0, 6) == 0) y = py;
      if ($urandom_range(0, 40) == 0) begin
        x = px;
        y = py;
      end
      poly_x.push_back(x);
      poly_y.push_back(y);
    end
    closed = ($urandom_range(0, 19) != 0);
    emit_polygon(px, py, bxl, byl, bxh, byh, closed);
  endtask

  initial begin
    in_item_t stray;
    int       base;
    int       waited;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    stray          = noise_item();
    stray.first    = 1'b0;
    stray.last     = 1'b1;
    stray.vertex_x = coord_t'(-3);
    stray.vertex_y = coord_t'(4);
    send_vertex(stray);

    poly_x = '{7};
    poly_y = '{2};
    emit_polygon(0, 0, CMIN, CMIN, CMAX, CMAX, 1'b1);
    poly_x = '{1};
    poly_y = '{1};
    emit_polygon(5, 0, 6, CMIN, 10, CMAX, 1'b1);
    emit_polygon(0, 40, CMIN, CMIN, CMAX, 39, 1'b1);
    poly_x = '{3, 9};
    poly_y = '{3, 9};
    emit_polygon(3, 3, CMIN, CMIN, CMAX, CMAX, 1'b1);
    poly_x = '{-10, 10, 10, -10};
    poly_y = '{-10, -10, 10, 10};
    emit_polygon(0, 0, -10, -10, 10, 10, 1'b1);
    poly_x = '{-10, 10, 0};
    poly_y = '{-10, -10, 10};
    emit_polygon(100, 100, CMIN, CMIN, CMAX, CMAX, 1'b1);
    poly_x = '{5, -5, -5};
    poly_y = '{0, 5, -5};
    emit_polygon(0, 0, CMIN, CMIN, CMAX, CMAX, 1'b1);
    poly_x = '{-5, 5, 5, 8};
    poly_y = '{-5, -5, 5, 0};
    emit_polygon(0, 0, CMIN, CMIN, CMAX, CMAX, 1'b1);
    poly_x = '{0, 2, 9};
    poly_y = '{0, 2, 9};
    emit_polygon(2, 2, CMIN, CMIN, CMAX, CMAX, 1'b1);
    poly_x = '{CMIN, CMAX, CMAX, CMIN};
    poly_y = '{CMIN, CMIN, CMAX, CMAX};
    emit_polygon(CMIN, CMAX, CMIN, CMIN, CMAX, CMAX, 1'b1);
    emit_polygon(CMAX - 1, CMIN + 1, CMIN, CMIN, CMAX, CMAX, 1'b1);

    base = items_sent;
    while (items_sent - base < 900) begin
      if (items_sent - base < 300) begin
        send_idle = 9;
        recv_idle = 49;
      end else if (items_sent - base < 600) begin
        send_idle = 49;
        recv_idle = 9;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          stray       = noise_item();
          stray.first = 1'b0;
          send_vertex(stray);
        end
      end else begin
        random_polygon();
      end
    end
    in_valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

### point_in_polygon_test.f
hdl/pip_pkg.sv
hdl/pip_front.sv
hdl/pip_queue.sv
hdl/pip_back.sv
hdl/point_in_polygon_test.sv
tb/sv/polygon_verdict_checker.sv
tb/sv/tb.sv
